/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CTFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ctfd check failed");

// checked on every edge, reset included
`define CTFD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ctfd reset check failed");

`endif

/* hw/rtl/ctfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ctfd_pkg;

  localparam int KEPT_BYTES  = 16;
  localparam int STORE_AW    = $clog2(KEPT_BYTES);
  // payload bytes the decoder looks at, type byte included
  localparam int DEC_BYTES   = 16;
  // power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W     = 3;

  localparam logic [7:0]  SYNC_RESET  = 8'hC8;
  localparam logic [15:0] ALT_OFFSET  = 16'd1000;
  localparam logic        REG_SYNC    = 1'b0;

  localparam logic [7:0] TYPE_BATTERY  = 8'h08;
  localparam logic [7:0] TYPE_GPS      = 8'h02;
  localparam logic [7:0] TYPE_VARIO    = 8'h07;
  localparam logic [7:0] TYPE_FMODE    = 8'h21;
  localparam logic [7:0] TYPE_ATTITUDE = 8'h1E;
  localparam logic [7:0] TYPE_LINK_RX  = 8'h1C;
  localparam logic [7:0] TYPE_LINK_TX  = 8'h1D;
  localparam logic [7:0] TYPE_MODEM    = 8'h88;
  localparam logic [7:0] TYPE_LSTATS   = 8'h14;

  typedef enum logic [3:0] {
    KIND_BATTERY    = 4'd0,
    KIND_GPS        = 4'd1,
    KIND_VARIO      = 4'd2,
    KIND_FMODE      = 4'd3,
    KIND_ATTITUDE   = 4'd4,
    KIND_LINK_RX    = 4'd5,
    KIND_LINK_TX    = 4'd6,
    KIND_MODEM      = 4'd7,
    KIND_LINK_STATS = 4'd8
  } kind_t;

  typedef struct packed {
    logic  known;
    kind_t kind;
  } class_t;

  // one finished frame, bytes past the frame end already zeroed
  typedef struct packed {
    kind_t                        kind;
    logic [7:0]                   frame_length;
    logic [DEC_BYTES-1:1][7:0]    pay;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic class_t classify_type(input logic [7:0] t);
    class_t c;
    c.known = 1'b1;
    c.kind  = KIND_BATTERY;
    case (t)
      TYPE_BATTERY:  c.kind = KIND_BATTERY;
      TYPE_GPS:      c.kind = KIND_GPS;
      TYPE_VARIO:    c.kind = KIND_VARIO;
      TYPE_FMODE:    c.kind = KIND_FMODE;
      TYPE_ATTITUDE: c.kind = KIND_ATTITUDE;
      TYPE_LINK_RX:  c.kind = KIND_LINK_RX;
      TYPE_LINK_TX:  c.kind = KIND_LINK_TX;
      TYPE_MODEM:    c.kind = KIND_MODEM;
      TYPE_LSTATS:   c.kind = KIND_LINK_STATS;
      default:       c.known = 1'b0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ctfd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface ctfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ctfd_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  frame_kind;
  logic [31:0] value0;
  logic [31:0] value1;
  logic [31:0] value2;
  logic [31:0] value3;
  logic [31:0] value4;
  logic [31:0] value5;
  logic [31:0] value6;
  logic [31:0] value7;
  logic [31:0] value8;
  logic [31:0] value9;

  modport source (output valid, output frame_kind, output value0, output value1,
                  output value2, output value3, output value4, output value5,
                  output value6, output value7, output value8, output value9,
                  input ready);
  modport sink   (input valid, input frame_kind, input value0, input value1,
                  input value2, input value3, input value4, input value5,
                  input value6, input value7, input value8, input value9,
                  output ready);
endinterface
`default_nettype wire

/* hw/rtl/ctfd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            sync_value,
  ctfd_byte_if.sink             in_ch,
  input  ctfd_pkg::q_status_t   q_stat,
  output logic                  push,
  output ctfd_pkg::frame_rec_t  push_rec
);
  import ctfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] frame_length;
  logic [7:0] bytes_seen;
  logic [7:0] store [KEPT_BYTES];
  logic       accept;
  logic [8:0] seen_inc;
  logic       last_byte;
  logic [7:0] type_byte;
  class_t     cls;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign seen_inc    = {1'b0, bytes_seen} + 9'd1;
  assign last_byte   = (phase == PH_DATA) && (seen_inc >= {1'b0, frame_length});
  // the last byte is not in the store yet, take it straight from the beat
  assign type_byte   = (bytes_seen == 8'd0) ? in_ch.in_byte : store[0];
  assign cls         = classify_type(type_byte);
  assign push        = accept && last_byte && cls.known;

  always_comb begin
    push_rec.kind         = cls.kind;
    push_rec.frame_length = frame_length;
    for (int i = 1; i < DEC_BYTES; i++) begin
      if (8'(i) < frame_length) begin
        push_rec.pay[i] = (bytes_seen == 8'(i)) ? in_ch.in_byte : store[i];
      end else begin
        push_rec.pay[i] = 8'd0;
      end
    end
  end

  always_comb begin
    case (phase)
      PH_LEN:  phase_next = (in_ch.in_byte == 8'd0) ? PH_HUNT : PH_DATA;
      PH_DATA: phase_next = last_byte ? PH_HUNT : PH_DATA;
      default: phase_next = (in_ch.in_byte == sync_value) ? PH_LEN : PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      frame_length <= 8'd0;
      bytes_seen   <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      if (phase == PH_LEN) begin
        frame_length <= in_ch.in_byte;
        bytes_seen   <= 8'd0;
      end else if (phase == PH_DATA) begin
        bytes_seen <= seen_inc[7:0];
      end
    end
  end

  // entries past the frame length are masked on read, so no clearing needed
  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && bytes_seen < 8'(KEPT_BYTES)) begin
      store[bytes_seen[STORE_AW-1:0]] <= in_ch.in_byte;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ctfd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ctfd_pkg::frame_rec_t  push_rec,
  input  logic                  pop,
  output ctfd_pkg::frame_rec_t  head,
  output ctfd_pkg::q_status_t   q_stat
);
  import ctfd_pkg::*;

  frame_rec_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ctfd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ctfd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ctfd_pkg::frame_rec_t  head,
  input  ctfd_pkg::q_status_t   q_stat,
  output logic                  pop,
  ctfd_result_if.source         out_ch
);
  import ctfd_pkg::*;

  logic        out_valid;
  logic [3:0]  kind_r;
  logic [31:0] vals [10];
  logic [31:0] v [10];
  logic [15:0] alt_raw;

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  assign pop     = !q_stat.empty && (!out_valid || out_ch.ready);
  assign alt_raw = {head.pay[13], head.pay[14]} - ALT_OFFSET;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      v[i] = 32'd0;
    end
    case (head.kind)
      KIND_BATTERY: begin
        v[0] = {16'd0, head.pay[1], head.pay[2]};
        v[1] = {16'd0, head.pay[3], head.pay[4]};
        v[2] = {8'd0, head.pay[5], head.pay[6], head.pay[7]};
        v[3] = {24'd0, head.pay[8]};
      end
      KIND_GPS: begin
        v[0] = {head.pay[1], head.pay[2], head.pay[3], head.pay[4]};
        v[1] = {head.pay[5], head.pay[6], head.pay[7], head.pay[8]};
        v[2] = {16'd0, head.pay[9], head.pay[10]};
        v[3] = {16'd0, head.pay[11], head.pay[12]};
        v[4] = {16'd0, alt_raw};
        v[5] = {24'd0, head.pay[15]};
      end
      KIND_VARIO: begin
        v[0] = {16'd0, head.pay[1], head.pay[2]};
      end
      KIND_FMODE: begin
        v[0] = {24'd0, head.frame_length - 8'd1};
      end
      KIND_ATTITUDE: begin
        v[0] = sx16({head.pay[1], head.pay[2]});
        v[1] = sx16({head.pay[3], head.pay[4]});
        v[2] = {16'd0, head.pay[5], head.pay[6]};
      end
      KIND_LINK_RX: begin
        v[0] = {24'd0, head.pay[1]};
        v[1] = {24'd0, head.pay[2]};
      end
      KIND_LINK_TX: begin
        v[0] = {24'd0, head.pay[1]};
        v[1] = {24'd0, head.pay[2]};
        v[2] = {24'd0, head.pay[3]};
      end
      KIND_MODEM: begin
        // rssi and rsrq come little-endian, rsrp big-endian
        v[0] = sx16({head.pay[2], head.pay[1]});
        v[1] = sx16({head.pay[4], head.pay[3]});
        v[2] = sx16({head.pay[5], head.pay[6]});
        v[3] = sx8(head.pay[7]);
      end
      KIND_LINK_STATS: begin
        for (int i = 0; i < 10; i++) begin
          v[i] = {24'd0, head.pay[i+1]};
        end
        v[3] = sx8(head.pay[4]);
        v[9] = sx8(head.pay[10]);
      end
      default: begin
        v[0] = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head.kind;
      for (int i = 0; i < 10; i++) begin
        vals[i] <= v[i];
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.frame_kind = kind_r;
  assign out_ch.value0     = vals[0];
  assign out_ch.value1     = vals[1];
  assign out_ch.value2     = vals[2];
  assign out_ch.value3     = vals[3];
  assign out_ch.value4     = vals[4];
  assign out_ch.value5     = vals[5];
  assign out_ch.value6     = vals[6];
  assign out_ch.value7     = vals[7];
  assign out_ch.value8     = vals[8];
  assign out_ch.value9     = vals[9];

endmodule
`default_nettype wire

/* hw/rtl/crsf_telemetry_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   role     beat
// in_ch     sink     one raw stream byte (in_byte)
// out_ch    source   one decoded frame (frame_kind, value0..value9)
// apb       target   sync_value at address 0, 32-bit data
//
// one byte per cycle; the byte front never waits on decoding, only on the
// two-entry frame queue being full.
// out_ch valid rises once the frame has passed the queue entry and the output register.
// synchronous reset clears the phase machine, queue and output valid;
// sync_value returns to 0xC8.
// a stalled out_ch holds its beat; bytes keep flowing until the queue fills.
module crsf_telemetry_frame_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctfd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  ctfd_byte_if.sink                     in_ch,
  ctfd_result_if.source                 out_ch
);
  import ctfd_pkg::*;

  logic       sync_value;
  logic [7:0] sync_reg;
  logic       cfg_write;
  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t head;
  q_status_t  q_stat;

  assign pready     = 1'b1;
  assign sync_value = (paddr[PADDR_W-1] == REG_SYNC);
  assign cfg_write  = psel && penable && pwrite && sync_value;
  assign prdata     = sync_value ? {24'd0, sync_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg <= SYNC_RESET;
    end else if (cfg_write) begin
      sync_reg <= pwdata[7:0];
    end
  end

  ctfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sync_value (sync_reg),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_rec   (push_rec)
  );

  ctfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  ctfd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

/* hw/rtl/ctfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctfd_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctfd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  input  logic [31:0]                   prdata,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [3:0]                    frame_kind,
  input  logic [31:0]                   value0,
  input  logic [31:0]                   value1,
  input  logic [31:0]                   value2,
  input  logic [31:0]                   value3,
  input  logic [31:0]                   value4,
  input  logic [31:0]                   value5,
  input  logic [31:0]                   value6,
  input  logic [31:0]                   value7,
  input  logic [31:0]                   value8,
  input  logic [31:0]                   value9
);
  import ctfd_pkg::*;

  logic upper_zero;
  logic sync_write;

  // vario carries only its first value
  assign upper_zero = (value1 == 32'd0) && (value2 == 32'd0) && (value3 == 32'd0) &&
                      (value4 == 32'd0) && (value5 == 32'd0) && (value6 == 32'd0) &&
                      (value7 == 32'd0) && (value8 == 32'd0) && (value9 == 32'd0);
  assign sync_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SYNC);

  `CTFD_ASSERT_RST(a_reset_clears_out, rst |=> !out_valid)
  `CTFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(value0))
  `CTFD_ASSERT(a_kind_range, out_valid |-> frame_kind <= KIND_LINK_STATS)
  `CTFD_ASSERT(a_vario_clean, out_valid && frame_kind == KIND_VARIO |-> upper_zero)
  `CTFD_ASSERT(a_sync_readback, sync_write |=> prdata[7:0] == $past(pwdata[7:0]) && prdata[31:8] == 24'd0)

endmodule

bind crsf_telemetry_frame_decoder ctfd_checker u_ctfd_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .frame_kind (out_ch.frame_kind),
  .value0     (out_ch.value0),
  .value1     (out_ch.value1),
  .value2     (out_ch.value2),
  .value3     (out_ch.value3),
  .value4     (out_ch.value4),
  .value5     (out_ch.value5),
  .value6     (out_ch.value6),
  .value7     (out_ch.value7),
  .value8     (out_ch.value8),
  .value9     (out_ch.value9)
);
`default_nettype wire
